// ----- rtl/rpn_stack_calculator_assert.svh -----
// Assertion macros for the RPN calculator checker
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Consequent checked in the cycle after the antecedent
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rpn_pkg.sv -----
// Shared types and character codes of the RPN calculator
package rpn_pkg;

  localparam int OUT_WIDTH = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

// ----- rtl/rpn_if.sv -----
// Valid/ready channel interfaces for characters in and results out
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface rpn_out_if;
  import rpn_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] value;
  logic                        underflow_seen;
  logic                        overflow_seen;
  logic                        div_zero_seen;

  modport source (output valid, output value, output underflow_seen,
                  output overflow_seen, output div_zero_seen, input ready);
  modport sink (input valid, input value, input underflow_seen,
                input overflow_seen, input div_zero_seen, output ready);
endinterface

// ----- rtl/rpn_stack_calculator.sv -----
// RPN calculator: one character per word in, one result word per expression out.
// A digit goes straight to S_PUSH; an ignored character stays in S_IDLE. An operator
// pops both operands (S_POPR, S_POPL) and runs the ALU (S_EXEC, S_WAIT) before S_PUSH;
// multiply and divide step the shared adder one bit per cycle. The end mark pops the top.
// Reset clears the stack count, the flags and the handshakes; the stack memory
// holds no reset value and is never cleared.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);
  import rpn_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPR,
    S_POPL,
    S_EXEC,
    S_WAIT,
    S_PUSH,
    S_FINAL,
    S_FINAL_CAP
  } state_t;

  state_t                  state_r;
  logic [CNTW-1:0]         count_r;
  logic                    under_r;
  logic                    over_r;
  logic                    divz_r;
  logic                    last_r;
  logic                    pend_r;
  alu_op_t                 op_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  logic [VALUE_WIDTH-1:0]  rhs_r;

  logic                    out_valid_r;
  logic [OUT_WIDTH-1:0]    out_value_r;
  logic                    out_under_r;
  logic                    out_over_r;
  logic                    out_divz_r;

  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [VALUE_WIDTH-1:0]  ram_rdata;
  logic [CNTW-1:0]         cnt_dec;
  logic                    pop_ok;
  logic                    full;
  logic [VALUE_WIDTH-1:0]  popped;
  logic                    is_digit;

  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;
  logic [VALUE_WIDTH-1:0]  alu_result;

  always_comb begin
    cnt_dec   = count_r - 1'b1;
    pop_ok    = (count_r != '0);
    full      = (count_r >= CNTW'(STACK_DEPTH));
    ram_we    = (state_r == S_PUSH) && !full;
    ram_re    = pop_ok && (state_r == S_POPR || state_r == S_POPL || state_r == S_FINAL);
    ram_raddr = cnt_dec[AW-1:0];
    // an empty pop reads as all ones
    popped    = pend_r ? ram_rdata : '1;
    is_digit  = (in_ch.char_code >= CH_ZERO) && (in_ch.char_code <= CH_NINE);
    alu_req.start = (state_r == S_EXEC);
    alu_req.op    = op_r;
  end

  rpn_stk_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(VALUE_WIDTH)
  ) u_ram (
    .clk      (clk),
    .wr_en    (ram_we),
    .wr_addr  (count_r[AW-1:0]),
    .wr_data  (val_r),
    .rd_en    (ram_re),
    .rd_addr  (ram_raddr),
    .rd_data_r(ram_rdata)
  );

  rpn_alu #(
    .WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (alu_req),
    .lhs     (popped),
    .rhs     (rhs_r),
    .rsp_r   (alu_rsp),
    .result_r(alu_result)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.value          = out_value_r;
  assign out_ch.underflow_seen = out_under_r;
  assign out_ch.overflow_seen  = out_over_r;
  assign out_ch.div_zero_seen  = out_divz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      divz_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            last_r <= in_ch.end_of_expr;
            val_r  <= VALUE_WIDTH'(in_ch.char_code[3:0]);
            priority if (is_digit) begin
              state_r <= S_PUSH;
            end else if (in_ch.char_code == CH_PLUS) begin
              op_r    <= OP_ADD;
              state_r <= S_POPR;
            end else if (in_ch.char_code == CH_MINUS) begin
              op_r    <= OP_SUB;
              state_r <= S_POPR;
            end else if (in_ch.char_code == CH_STAR) begin
              op_r    <= OP_MUL;
              state_r <= S_POPR;
            end else if (in_ch.char_code == CH_SLASH) begin
              op_r    <= OP_DIV;
              state_r <= S_POPR;
            end else if (in_ch.end_of_expr) begin
              state_r <= S_FINAL;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_POPR: begin
          pend_r <= pop_ok;
          if (pop_ok) begin
            count_r <= cnt_dec;
          end else begin
            under_r <= 1'b1;
          end
          state_r <= S_POPL;
        end
        S_POPL: begin
          rhs_r  <= popped;
          pend_r <= pop_ok;
          if (pop_ok) begin
            count_r <= cnt_dec;
          end else begin
            under_r <= 1'b1;
          end
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            val_r <= alu_result;
            if (alu_rsp.div_zero) begin
              divz_r <= 1'b1;
            end
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          // drop the word when the stack is full
          if (full) begin
            over_r <= 1'b1;
          end else begin
            count_r <= count_r + 1'b1;
          end
          state_r <= last_r ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          pend_r <= pop_ok;
          if (pop_ok) begin
            count_r <= cnt_dec;
          end else begin
            under_r <= 1'b1;
          end
          state_r <= S_FINAL_CAP;
        end
        S_FINAL_CAP: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= OUT_WIDTH'($signed(popped));
            out_under_r <= under_r;
            out_over_r  <= over_r;
            out_divz_r  <= divz_r;
            count_r     <= '0;
            under_r     <= 1'b0;
            over_r      <= 1'b0;
            divz_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/rpn_stk_ram.sv -----
// Stack storage: one write port, one read port with registered data
module rpn_stk_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rpn_alu.sv -----
// Shared-adder arithmetic unit: add/sub in one pass, shift-add multiply, restoring divide
module rpn_alu #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::alu_req_t req,
  input  logic [WIDTH-1:0]  lhs,
  input  logic [WIDTH-1:0]  rhs,
  output rpn_pkg::alu_rsp_t rsp_r,
  output logic [WIDTH-1:0]  result_r
);
  import rpn_pkg::*;

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    A_IDLE,
    A_NEGA,
    A_NEGB,
    A_MUL,
    A_DIV,
    A_NEGQ
  } astate_t;

  astate_t          state_r;
  logic [WIDTH-1:0] opa_r;
  logic [WIDTH-1:0] opb_r;
  logic [WIDTH-1:0] quo_r;
  logic [WIDTH:0]   rem_r;
  logic             neg_q_r;
  logic [CW-1:0]    cnt_r;

  logic [WIDTH+1:0] add_x;
  logic [WIDTH+1:0] add_y;
  logic             add_sub;
  logic [WIDTH+1:0] sum;

  // one adder, operands picked by the sequencer step
  always_comb begin
    add_x   = {2'b00, lhs};
    add_y   = {2'b00, rhs};
    add_sub = (req.op == OP_SUB);
    unique case (state_r)
      A_IDLE: begin
      end
      A_NEGA: begin
        add_x   = '0;
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
      end
      A_NEGB: begin
        add_x   = '0;
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
      end
      A_MUL: begin
        add_x   = {2'b00, rem_r[WIDTH-1:0]};
        add_y   = {2'b00, opa_r};
        add_sub = 1'b0;
      end
      A_DIV: begin
        add_x   = {rem_r, quo_r[WIDTH-1]};
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
      end
      A_NEGQ: begin
        add_x   = '0;
        add_y   = {2'b00, quo_r};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    sum = add_x + (add_sub ? ~add_y : add_y) + {{(WIDTH+1){1'b0}}, add_sub};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      rsp_r   <= '0;
    end else begin
      rsp_r <= '0;
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            opa_r   <= lhs;
            opb_r   <= rhs;
            quo_r   <= rhs;
            rem_r   <= '0;
            neg_q_r <= lhs[WIDTH-1] ^ rhs[WIDTH-1];
            cnt_r   <= CW'(WIDTH - 1);
            unique case (req.op)
              OP_ADD, OP_SUB: begin
                result_r   <= sum[WIDTH-1:0];
                rsp_r.done <= 1'b1;
              end
              OP_MUL: begin
                state_r <= A_MUL;
              end
              OP_DIV: begin
                if (rhs == '0) begin
                  result_r       <= '0;
                  rsp_r.done     <= 1'b1;
                  rsp_r.div_zero <= 1'b1;
                end else begin
                  state_r <= A_NEGA;
                end
              end
            endcase
          end
        end
        A_NEGA: begin
          if (opa_r[WIDTH-1]) begin
            opa_r <= sum[WIDTH-1:0];
          end
          state_r <= A_NEGB;
        end
        A_NEGB: begin
          if (opb_r[WIDTH-1]) begin
            opb_r <= sum[WIDTH-1:0];
          end
          quo_r   <= opa_r;
          rem_r   <= '0;
          state_r <= A_DIV;
        end
        A_MUL: begin
          // add multiplicand where the multiplier bit is set, then shift both
          if (quo_r[0]) begin
            rem_r <= {1'b0, sum[WIDTH-1:0]};
          end
          opa_r <= {opa_r[WIDTH-2:0], 1'b0};
          quo_r <= {1'b0, quo_r[WIDTH-1:1]};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            result_r   <= quo_r[0] ? sum[WIDTH-1:0] : rem_r[WIDTH-1:0];
            rsp_r.done <= 1'b1;
            state_r    <= A_IDLE;
          end
        end
        A_DIV: begin
          // keep the trial difference when it did not borrow
          if (!sum[WIDTH+1]) begin
            rem_r <= sum[WIDTH:0];
            quo_r <= {quo_r[WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[WIDTH-1:0], quo_r[WIDTH-1]};
            quo_r <= {quo_r[WIDTH-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= A_NEGQ;
          end
        end
        A_NEGQ: begin
          result_r   <= neg_q_r ? sum[WIDTH-1:0] : quo_r;
          rsp_r.done <= 1'b1;
          state_r    <= A_IDLE;
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/rpn_sva.sv -----
// Port-level checker for the RPN calculator and its bind
module rpn_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_under,
  input logic        out_over,
  input logic        out_divz
);

`include "rpn_stack_calculator_assert.svh"

  // taking an end-marked word always leaves the block busy, as it leads to a push or the final pop
  `RPN_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_end, !in_ready, "ready after last word")

  // a word without end mark never produces a result
  `RPN_ASSERT_NEXT(a_no_result_mid, in_valid && in_ready && !in_end && !out_valid, !out_valid, "result without end mark")

  `RPN_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(out_value) && $stable({out_under, out_over, out_divz}), "result changed while stalled")

  // a new result is loaded only from the busy final-pop step
  `RPN_ASSERT_NOW(a_result_from_busy, $rose(out_valid), !$past(in_ready), "result appeared from idle")

endmodule

bind rpn_stack_calculator rpn_sva u_rpn_sva (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_end   (in_ch.end_of_expr),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_value(out_ch.value),
  .out_under(out_ch.underflow_seen),
  .out_over (out_ch.overflow_seen),
  .out_divz (out_ch.div_zero_seen)
);

// ----- tb/sv/tb_rpn_stack_calculator.sv -----
// Testbench for rpn_stack_calculator: drives expressions, predicts results, checks every result word
module tb_rpn_stack_calculator;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int RANDOM_WORDS = 950;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DEL   = 8'hFF;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        underflow;
    logic                        overflow;
    logic                        div_zero;
  } calc_result_t;

  logic clk;
  logic rst_n;

  rpn_in_if  char_ch ();
  rpn_out_if result_ch ();

  rpn_stack_calculator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_ch),
    .out_ch (result_ch)
  );

  // predicted calculator state
  logic [OUT_WIDTH-1:0] calc_stack [STACK_DEPTH];
  int unsigned          calc_depth = 0;
  logic                 seen_under = 1'b0;
  logic                 seen_over  = 1'b0;
  logic                 seen_divz  = 1'b0;

  char_word_t   pending_chars[$];
  calc_result_t expected_results[$];

  char_word_t char_cur = '{code: 8'h00, last: 1'b0};
  bit         char_loaded  = 1'b0;
  bit         char_burst   = 1'b0;
  int         char_gap     = 0;
  bit         result_burst = 1'b0;
  int         result_stall = 0;

  int words_planned   = 0;
  int chars_accepted  = 0;
  int results_checked = 0;
  int under_results   = 0;
  int over_results    = 0;
  int divz_results    = 0;
  int mismatches      = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic bit decode_op(input logic [7:0] code, output alu_op_t op);
    op = OP_ADD;
    case (code)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit is_digit(logic [7:0] code);
    return code >= CH_ZERO && code <= CH_NINE;
  endfunction

  function automatic bit is_meaningful(logic [7:0] code);
    alu_op_t op;
    return is_digit(code) || decode_op(code, op);
  endfunction

  function automatic void stack_push(logic [OUT_WIDTH-1:0] v);
    if (calc_depth >= STACK_DEPTH) begin
      seen_over = 1'b1;
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endfunction

  function automatic logic [OUT_WIDTH-1:0] stack_pop();
    if (calc_depth == 0) begin
      seen_under = 1'b1;
      return '1;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  // truncate toward zero; the most negative value over -1 wraps back to itself
  function automatic logic [OUT_WIDTH-1:0] signed_quotient(logic [OUT_WIDTH-1:0] num,
                                                           logic [OUT_WIDTH-1:0] den);
    longint n;
    longint d;
    if (den == '0) begin
      seen_divz = 1'b1;
      return '0;
    end
    n = longint'($signed(num));
    d = longint'($signed(den));
    return OUT_WIDTH'(n / d);
  endfunction

  function automatic void apply_char(char_word_t w);
    alu_op_t              op;
    logic [OUT_WIDTH-1:0] lhs;
    logic [OUT_WIDTH-1:0] rhs;
    logic [OUT_WIDTH-1:0] res;
    calc_result_t         r;
    if (is_digit(w.code)) begin
      stack_push(OUT_WIDTH'(w.code - CH_ZERO));
    end else if (decode_op(w.code, op)) begin
      rhs = stack_pop();
      lhs = stack_pop();
      case (op)
        OP_ADD: res = lhs + rhs;
        OP_SUB: res = lhs - rhs;
        OP_MUL: res = lhs * rhs;
        OP_DIV: res = signed_quotient(lhs, rhs);
      endcase
      stack_push(res);
    end
    if (w.last) begin
      r.value     = stack_pop();
      r.underflow = seen_under;
      r.overflow  = seen_over;
      r.div_zero  = seen_divz;
      expected_results.push_back(r);
      calc_depth = 0;
      seen_under = 1'b0;
      seen_over  = 1'b0;
      seen_divz  = 1'b0;
    end
  endfunction

  task automatic check_result();
    calc_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected", result_ch.value));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    under_results += want.underflow;
    over_results  += want.overflow;
    divz_results  += want.div_zero;
    if (result_ch.value !== want.value) begin
      report_mismatch($sformatf("value %0d, want %0d", result_ch.value, want.value));
    end
    if (result_ch.underflow_seen !== want.underflow) begin
      report_mismatch($sformatf("underflow_seen %b, want %b",
                                result_ch.underflow_seen, want.underflow));
    end
    if (result_ch.overflow_seen !== want.overflow) begin
      report_mismatch($sformatf("overflow_seen %b, want %b",
                                result_ch.overflow_seen, want.overflow));
    end
    if (result_ch.div_zero_seen !== want.div_zero) begin
      report_mismatch($sformatf("div_zero_seen %b, want %b",
                                result_ch.div_zero_seen, want.div_zero));
    end
  endtask

  function automatic void queue_char(logic [7:0] code, logic last = 1'b0);
    char_word_t w;
    w.code = code;
    w.last = last;
    pending_chars.push_back(w);
    words_planned++;
  endfunction

  function automatic logic [7:0] digit_char(int d);
    return CH_ZERO + 8'(d);
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_ignored();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_meaningful(c));
    return c;
  endfunction

  // well-formed expression; the deep form stacks every operand first to hit a full stack
  function automatic void queue_rpn_expr(bit deep);
    int         operands;
    int         depth;
    logic [7:0] tok[$];
    operands = deep ? $urandom_range(14, 19) : $urandom_range(1, 7);
    depth = 0;
    for (int i = 0; i < operands; i++) begin
      if (deep && $urandom_range(0, 1)) begin
        tok.push_back(CH_NINE);
      end else begin
        tok.push_back(digit_char($urandom_range(0, 9)));
      end
      depth++;
      while (!deep && depth >= 2 && $urandom_range(0, 1)) begin
        tok.push_back(random_op());
        depth--;
      end
      if ($urandom_range(0, 9) == 0) begin
        tok.push_back(random_ignored());
      end
    end
    while (depth > 1) begin
      tok.push_back((deep && $urandom_range(0, 1)) ? CH_STAR : random_op());
      depth--;
    end
    foreach (tok[i]) begin
      queue_char(tok[i], i == tok.size() - 1);
    end
  endfunction

  function automatic void queue_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endfunction

  // build the most negative value as 8^10 * 2, then divide it by -1
  function automatic void queue_min_over_minus_one();
    queue_char(digit_char(8));
    repeat (9) begin
      queue_char(digit_char(8));
      queue_char(CH_STAR);
    end
    queue_char(digit_char(2));
    queue_char(CH_STAR);
    queue_char(digit_char(0));
    queue_char(digit_char(1));
    queue_char(CH_MINUS);
    queue_char(CH_SLASH, 1'b1);
  endfunction

  // character driver
  always @(posedge clk) begin
    if (!rst_n) begin
      char_ch.valid       <= 1'b0;
      char_ch.char_code   <= '0;
      char_ch.end_of_expr <= 1'b0;
      char_loaded = 1'b0;
      char_gap    = 0;
    end else begin
      if (char_loaded && char_ch.ready) begin
        apply_char(char_cur);
        chars_accepted++;
        char_loaded = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          char_burst = !char_burst;
        end
        char_gap = char_burst ? 0 : $urandom_range(0, 3);
      end
      if (!char_loaded) begin
        if (char_gap > 0) begin
          char_gap--;
        end else if (pending_chars.size() > 0) begin
          char_cur    = pending_chars.pop_front();
          char_loaded = 1'b1;
        end
      end
      char_ch.valid       <= char_loaded;
      char_ch.char_code   <= char_cur.code;
      char_ch.end_of_expr <= char_cur.last;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
      result_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        check_result();
        if ($urandom_range(0, 39) == 0) begin
          result_burst = !result_burst;
        end
        result_stall = result_burst ? 0 : $urandom_range(0, 3);
      end else if (result_stall > 0) begin
        result_stall--;
      end
      result_ch.ready <= (result_stall == 0);
    end
  end

  initial begin
    int base;
    int pick;
    rst_n               = 1'b0;
    char_ch.valid       = 1'b0;
    char_ch.char_code   = '0;
    char_ch.end_of_expr = 1'b0;
    result_ch.ready     = 1'b0;

    // full stack: the seventeenth digit is dropped
    repeat (16) queue_char(CH_NINE);
    queue_char(digit_char(8));
    queue_char(CH_PLUS, 1'b1);
    // divide by zero with an empty left operand
    queue_char(CH_DEL);
    queue_char(CH_ZERO);
    queue_char(CH_SLASH, 1'b1);
    // end mark on an empty stack
    queue_char(CH_NUL, 1'b1);
    queue_char(digit_char(3));
    queue_char(digit_char(5));
    queue_char(CH_MINUS);
    queue_char(digit_char(7));
    queue_char(CH_STAR, 1'b1);

    base = words_planned;
    queue_min_over_minus_one();
    while (words_planned - base < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 74) begin
        queue_rpn_expr(1'b0);
      end else if (pick < 84) begin
        queue_rpn_expr(1'b1);
      end else if (pick < 96) begin
        queue_noise();
      end else begin
        queue_min_over_minus_one();
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(negedge clk);
    end while (pending_chars.size() != 0 || char_loaded || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d characters accepted, %0d expression results checked",
             chars_accepted, results_checked);
    $display("tb: results flagged underflow %0d, overflow %0d, divide by zero %0d",
             under_results, over_results, divz_results);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_if.sv
rtl/rpn_stk_ram.sv
rtl/rpn_alu.sv
rtl/rpn_stack_calculator.sv
rtl/rpn_sva.sv
tb/sv/tb_rpn_stack_calculator.sv
